FILE: hw/rtl/stt_pkg.sv
// Shared types, token codes and keyword table for the source text tokenizer.
package stt_pkg;

  localparam int unsigned POS_BITS     = 16;
  localparam int unsigned KW_CHARS     = 8;
  localparam int unsigned PREFIX_CHARS = 8;
  localparam int unsigned PREFIX_BITS  = 8 * PREFIX_CHARS;
  localparam int unsigned KIND_BITS    = 5;
  localparam int unsigned KW_COUNT     = 10;
  localparam int unsigned RES_DEPTH    = 4;
  localparam int unsigned RES_PTR_BITS = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_BITS = $clog2(RES_DEPTH + 1);

  // Token kinds
  localparam logic [KIND_BITS-1:0] TK_NUMBER     = 5'd0;
  localparam logic [KIND_BITS-1:0] TK_IDENT      = 5'd1;
  localparam logic [KIND_BITS-1:0] TK_INT        = 5'd2;
  localparam logic [KIND_BITS-1:0] TK_FLOAT      = 5'd3;
  localparam logic [KIND_BITS-1:0] TK_BOOL       = 5'd4;
  localparam logic [KIND_BITS-1:0] TK_CHAR       = 5'd5;
  localparam logic [KIND_BITS-1:0] TK_PLUS       = 5'd6;
  localparam logic [KIND_BITS-1:0] TK_MINUS      = 5'd7;
  localparam logic [KIND_BITS-1:0] TK_STAR       = 5'd8;
  localparam logic [KIND_BITS-1:0] TK_DIVIDE     = 5'd9;
  localparam logic [KIND_BITS-1:0] TK_EQUALS     = 5'd10;
  localparam logic [KIND_BITS-1:0] TK_EQ_EQ      = 5'd11;
  localparam logic [KIND_BITS-1:0] TK_BANG_EQ    = 5'd12;
  localparam logic [KIND_BITS-1:0] TK_LESS       = 5'd13;
  localparam logic [KIND_BITS-1:0] TK_LESS_EQ    = 5'd14;
  localparam logic [KIND_BITS-1:0] TK_GREATER    = 5'd15;
  localparam logic [KIND_BITS-1:0] TK_GREATER_EQ = 5'd16;
  localparam logic [KIND_BITS-1:0] TK_PRINTOUT   = 5'd17;
  localparam logic [KIND_BITS-1:0] TK_FUNCTION   = 5'd18;
  localparam logic [KIND_BITS-1:0] TK_IF         = 5'd19;
  localparam logic [KIND_BITS-1:0] TK_ELSE       = 5'd20;
  localparam logic [KIND_BITS-1:0] TK_WHILE      = 5'd21;
  localparam logic [KIND_BITS-1:0] TK_FOR        = 5'd22;
  localparam logic [KIND_BITS-1:0] TK_LPAREN     = 5'd23;
  localparam logic [KIND_BITS-1:0] TK_RPAREN     = 5'd24;
  localparam logic [KIND_BITS-1:0] TK_LBRACE     = 5'd25;
  localparam logic [KIND_BITS-1:0] TK_RBRACE     = 5'd26;
  localparam logic [KIND_BITS-1:0] TK_COMMA      = 5'd27;
  localparam logic [KIND_BITS-1:0] TK_EOF        = 5'd28;
  localparam logic [KIND_BITS-1:0] TK_UNKNOWN    = 5'd29;

  // Keywords, bytes packed first-character-most-significant, zero padded on the left
  localparam logic [PREFIX_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0000_0069_6E74,  // int
    64'h0000_0066_6C6F_6174,  // float
    64'h0000_0000_626F_6F6C,  // bool
    64'h0000_0000_6368_6172,  // char
    64'h7072_696E_744F_7574,  // printOut
    64'h6675_6E63_7469_6F6E,  // function
    64'h0000_0000_0000_6966,  // if
    64'h0000_0000_656C_7365,  // else
    64'h0000_0077_6869_6C65,  // while
    64'h0000_0000_0066_6F72   // for
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd4, 4'd4, 4'd8, 4'd8, 4'd2, 4'd4, 4'd5, 4'd3
  };
  localparam logic [KIND_BITS-1:0] KW_CODE [KW_COUNT] = '{
    TK_INT, TK_FLOAT, TK_BOOL, TK_CHAR, TK_PRINTOUT,
    TK_FUNCTION, TK_IF, TK_ELSE, TK_WHILE, TK_FOR
  };

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [POS_BITS-1:0]  line;
    logic [POS_BITS-1:0]  column;
    logic [POS_BITS-1:0]  length;
    logic                 last;
  } token_t;

  // Up to two tokens per source item; slot 0 goes out first
  typedef struct packed {
    logic   v0;
    token_t t0;
    logic   v1;
    token_t t1;
  } res_pair_t;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    logic [POS_BITS-1:0] r;
    r = (v == '1) ? v : v + POS_BITS'(1);
    return r;
  endfunction

  function automatic logic [KIND_BITS-1:0] kw_kind(input logic [POS_BITS-1:0]    len,
                                                   input logic [PREFIX_BITS-1:0] prefix);
    logic [KIND_BITS-1:0] k;
    k = TK_IDENT;
    if (len <= POS_BITS'(KW_CHARS)) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if (len == POS_BITS'(KW_LEN[i]) && prefix == KW_TEXT[i]) k = KW_CODE[i];
      end
    end
    return k;
  endfunction

endpackage

FILE: hw/rtl/stt_if.sv
// Handshake channels of the tokenizer: source bytes in, tokens out.
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;

  modport source (output valid, kind, char_code, input ready);
  modport sink   (input valid, kind, char_code, output ready);
endinterface

interface stt_out_if;
  logic                                valid;
  logic                                ready;
  logic [stt_pkg::KIND_BITS-1:0]       token_kind;
  logic [stt_pkg::POS_BITS-1:0]        start_line;
  logic [stt_pkg::POS_BITS-1:0]        start_column;
  logic [stt_pkg::POS_BITS-1:0]        token_length;
  logic                                last;

  modport source (output valid, token_kind, start_line, start_column, token_length, last,
                  input ready);
  modport sink   (input valid, token_kind, start_line, start_column, token_length, last,
                  output ready);
endinterface

FILE: hw/rtl/stt_core.sv
// Scanner state and the single-pass token decision for one registered source item.
module stt_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic                  kind_i,
  input  logic [7:0]            char_i,
  output stt_pkg::res_pair_t    res_o
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_NUMBER  = 4'd1;
  localparam logic [3:0] M_WORD    = 4'd2;
  localparam logic [3:0] M_SLASH   = 4'd3;
  localparam logic [3:0] M_COMMENT = 4'd4;
  localparam logic [3:0] M_EQ      = 4'd5;
  localparam logic [3:0] M_BANG    = 4'd6;
  localparam logic [3:0] M_LT      = 4'd7;
  localparam logic [3:0] M_GT      = 4'd8;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam int unsigned PB = stt_pkg::POS_BITS;

  logic [3:0]                        mode_q, mode_d;
  logic [PB-1:0]                     cur_line_q, cur_line_d;
  logic [PB-1:0]                     cur_col_q, cur_col_d;
  logic [PB-1:0]                     tok_line_q, tok_line_d;
  logic [PB-1:0]                     tok_col_q, tok_col_d;
  logic [PB-1:0]                     tok_len_q, tok_len_d;
  logic [stt_pkg::PREFIX_BITS-1:0]   prefix_q, prefix_d;

  logic                              is_digit, is_alpha, is_word, is_eq;
  logic                              pend_v;
  stt_pkg::token_t                   pend_tok;
  logic [stt_pkg::KIND_BITS-1:0]     pend_kind, two_kind, single_kind;
  logic [PB-1:0]                     pend_len;
  stt_pkg::res_pair_t                res;

  assign is_digit = (char_i >= 8'h30) && (char_i <= 8'h39);
  assign is_alpha = ((char_i >= 8'h41) && (char_i <= 8'h5A)) ||
                    ((char_i >= 8'h61) && (char_i <= 8'h7A));
  assign is_word  = is_alpha || is_digit || (char_i == CH_UNDER);
  assign is_eq    = (char_i == CH_EQ);

  // Token held open by the current mode, emitted when the run ends
  always_comb begin
    pend_v    = 1'b1;
    pend_kind = stt_pkg::TK_UNKNOWN;
    pend_len  = PB'(1);
    unique case (mode_q)
      M_NUMBER: begin
        pend_kind = stt_pkg::TK_NUMBER;
        pend_len  = tok_len_q;
      end
      M_WORD: begin
        pend_kind = stt_pkg::kw_kind(tok_len_q, prefix_q);
        pend_len  = tok_len_q;
      end
      M_SLASH: pend_kind = stt_pkg::TK_DIVIDE;
      M_EQ:    pend_kind = stt_pkg::TK_EQUALS;
      M_BANG:  pend_kind = stt_pkg::TK_UNKNOWN;
      M_LT:    pend_kind = stt_pkg::TK_LESS;
      M_GT:    pend_kind = stt_pkg::TK_GREATER;
      default: pend_v    = 1'b0;
    endcase
    pend_tok = '{kind: pend_kind, line: tok_line_q, column: tok_col_q,
                 length: pend_len, last: 1'b0};
  end

  always_comb begin
    two_kind = stt_pkg::TK_GREATER_EQ;
    case (mode_q)
      M_EQ:    two_kind = stt_pkg::TK_EQ_EQ;
      M_BANG:  two_kind = stt_pkg::TK_BANG_EQ;
      M_LT:    two_kind = stt_pkg::TK_LESS_EQ;
      default: two_kind = stt_pkg::TK_GREATER_EQ;
    endcase
  end

  always_comb begin
    single_kind = stt_pkg::TK_UNKNOWN;
    case (char_i)
      CH_PLUS:   single_kind = stt_pkg::TK_PLUS;
      CH_MINUS:  single_kind = stt_pkg::TK_MINUS;
      CH_STAR:   single_kind = stt_pkg::TK_STAR;
      CH_LPAREN: single_kind = stt_pkg::TK_LPAREN;
      CH_RPAREN: single_kind = stt_pkg::TK_RPAREN;
      CH_LBRACE: single_kind = stt_pkg::TK_LBRACE;
      CH_RBRACE: single_kind = stt_pkg::TK_RBRACE;
      CH_COMMA:  single_kind = stt_pkg::TK_COMMA;
      default:   single_kind = stt_pkg::TK_UNKNOWN;
    endcase
  end

  always_comb begin
    mode_d     = mode_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    tok_len_d  = tok_len_q;
    prefix_d   = prefix_q;
    res        = '0;

    if (kind_i) begin
      // End of source: flush, emit eof, return to reset values
      res.v0     = pend_v;
      res.t0     = pend_tok;
      res.v1     = 1'b1;
      res.t1     = '{kind: stt_pkg::TK_EOF, line: cur_line_q, column: cur_col_q,
                     length: '0, last: 1'b1};
      mode_d     = M_IDLE;
      cur_line_d = PB'(1);
      cur_col_d  = PB'(1);
      tok_line_d = PB'(1);
      tok_col_d  = PB'(1);
      tok_len_d  = '0;
      prefix_d   = '0;
    end else if (mode_q == M_NUMBER && is_digit) begin
      tok_len_d = stt_pkg::sat_inc(tok_len_q);
      cur_col_d = stt_pkg::sat_inc(cur_col_q);
    end else if (mode_q == M_WORD && is_word) begin
      if (tok_len_q < PB'(stt_pkg::PREFIX_CHARS)) begin
        prefix_d = {prefix_q[stt_pkg::PREFIX_BITS-9:0], char_i};
      end
      tok_len_d = stt_pkg::sat_inc(tok_len_q);
      cur_col_d = stt_pkg::sat_inc(cur_col_q);
    end else if (mode_q == M_SLASH && char_i == CH_SLASH) begin
      mode_d    = M_COMMENT;
      cur_col_d = stt_pkg::sat_inc(cur_col_q);
    end else if (mode_q == M_COMMENT && char_i != CH_NL) begin
      cur_col_d = stt_pkg::sat_inc(cur_col_q);
    end else if ((mode_q inside {M_EQ, M_BANG, M_LT, M_GT}) && is_eq) begin
      res.v1    = 1'b1;
      res.t1    = '{kind: two_kind, line: tok_line_q, column: tok_col_q,
                    length: PB'(2), last: 1'b0};
      cur_col_d = stt_pkg::sat_inc(cur_col_q);
      mode_d    = M_IDLE;
    end else begin
      // Run ended: flush what is open, then start on this byte
      res.v0     = pend_v;
      res.t0     = pend_tok;
      mode_d     = M_IDLE;
      tok_line_d = cur_line_q;
      tok_col_d  = cur_col_q;
      if (char_i == CH_NL) begin
        cur_line_d = stt_pkg::sat_inc(cur_line_q);
        cur_col_d  = PB'(1);
      end else begin
        cur_col_d = stt_pkg::sat_inc(cur_col_q);
        if (is_digit) begin
          mode_d    = M_NUMBER;
          tok_len_d = PB'(1);
        end else if (is_alpha || char_i == CH_UNDER) begin
          mode_d    = M_WORD;
          tok_len_d = PB'(1);
          prefix_d  = stt_pkg::PREFIX_BITS'(char_i);
        end else begin
          case (char_i)
            CH_SPACE, CH_TAB, CH_CR: mode_d = M_IDLE;
            CH_SLASH: mode_d = M_SLASH;
            CH_EQ:    mode_d = M_EQ;
            CH_BANG:  mode_d = M_BANG;
            CH_LT:    mode_d = M_LT;
            CH_GT:    mode_d = M_GT;
            default: begin
              res.v1 = 1'b1;
              res.t1 = '{kind: single_kind, line: cur_line_q, column: cur_col_q,
                         length: PB'(1), last: 1'b0};
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= M_IDLE;
      cur_line_q <= PB'(1);
      cur_col_q  <= PB'(1);
      tok_line_q <= PB'(1);
      tok_col_q  <= PB'(1);
      tok_len_q  <= '0;
      prefix_q   <= '0;
    end else if (fire_i) begin
      mode_q     <= mode_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      tok_len_q  <= tok_len_d;
      prefix_q   <= prefix_d;
    end
  end

  assign res_o = res;

endmodule

FILE: hw/rtl/stt_res_fifo.sv
// Result queue: takes zero to two tokens per item, hands out one per transfer.
module stt_res_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  stt_pkg::res_pair_t  res_i,
  input  logic                pop_ready_i,
  output logic                room_o,
  output logic                valid_o,
  output stt_pkg::token_t     tok_o
);

  localparam int unsigned PW = stt_pkg::RES_PTR_BITS;
  localparam int unsigned CW = stt_pkg::RES_CNT_BITS;

  stt_pkg::token_t   mem_q [stt_pkg::RES_DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [CW-1:0]     count_q, count_d;
  logic [1:0]        n_push;
  logic              pop;
  stt_pkg::token_t   first_tok;

  assign n_push    = push_i ? ({1'b0, res_i.v0} + {1'b0, res_i.v1}) : 2'd0;
  assign first_tok = res_i.v0 ? res_i.t0 : res_i.t1;
  assign wr_ptr_nx = wr_ptr_q + PW'(1);
  assign valid_o   = (count_q != '0);
  assign pop       = valid_o && pop_ready_i;
  assign tok_o     = mem_q[rd_ptr_q];
  // Leave space for the worst case of two tokens
  assign room_o    = (count_q <= CW'(stt_pkg::RES_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(n_push);
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q + CW'(n_push) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wr_ptr_q] <= first_tok;
    if (n_push == 2'd2) mem_q[wr_ptr_nx] <= res_i.t1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: hw/rtl/source_text_tokenizer.sv
// Top level of the streaming source text tokenizer.
//
//   channel  dir  payload                                                  last item
//   src_i    in   kind, char_code                                          kind = 1
//   res_o    out  token_kind, start_line, start_column, token_length, last  last = 1
//
// Each item is registered on transfer, then scanned into 0, 1 or 2 tokens that go into
// a four-entry result queue; one item per cycle is taken while the queue has room.
// Tokens leave one per cycle while res_o.ready is high, so a stream of items that each
// give two tokens is held back by the single output port.
// The input stage holds while the queue has fewer than two free entries.
// Reset clears the scanner to line 1, column 1 and empties the queue.
module source_text_tokenizer (
  input  logic           clk_i,
  input  logic           rst_ni,
  stt_in_if.sink         src_i,
  stt_out_if.source      res_o
);

  logic                 in_valid_q;
  logic                 in_kind_q;
  logic [7:0]           in_char_q;
  logic                 room;
  logic                 fire;
  logic                 in_xfer;
  stt_pkg::res_pair_t   res_pair;
  stt_pkg::token_t      tok;

  assign fire        = in_valid_q && room;
  assign src_i.ready = !in_valid_q || fire;
  assign in_xfer     = src_i.valid && src_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (src_i.ready) begin
      in_valid_q <= src_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_kind_q <= src_i.kind;
      in_char_q <= src_i.char_code;
    end
  end

  stt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .kind_i (in_kind_q),
    .char_i (in_char_q),
    .res_o  (res_pair)
  );

  stt_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .res_i       (res_pair),
    .pop_ready_i (res_o.ready),
    .room_o      (room),
    .valid_o     (res_o.valid),
    .tok_o       (tok)
  );

  assign res_o.token_kind   = tok.kind;
  assign res_o.start_line   = tok.line;
  assign res_o.start_column = tok.column;
  assign res_o.token_length = tok.length;
  assign res_o.last         = tok.last;

endmodule

FILE: hw/rtl/stt_checker.sv
// Port-level checks on the tokenizer output stream, bound to the top level.
module stt_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                res_valid_i,
  input logic                                res_ready_i,
  input logic [stt_pkg::KIND_BITS-1:0]       token_kind_i,
  input logic [stt_pkg::POS_BITS-1:0]        start_line_i,
  input logic [stt_pkg::POS_BITS-1:0]        start_column_i,
  input logic [stt_pkg::POS_BITS-1:0]        token_length_i,
  input logic                                last_i
);

  // The closing token is eof and carries no text
  a_last_is_eof : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && last_i |-> token_kind_i == stt_pkg::TK_EOF && token_length_i == '0)
    else $error("last token is not an empty eof");

  a_eof_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && token_kind_i == stt_pkg::TK_EOF |-> last_i)
    else $error("eof token without last");

  a_text_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !last_i |-> token_length_i != '0)
    else $error("non-eof token of zero length");

  a_pos_one_based : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> start_line_i != '0 && start_column_i != '0)
    else $error("token position is zero");

  a_hold_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(token_kind_i) &&
      $stable(start_line_i) && $stable(start_column_i) && $stable(token_length_i) &&
      $stable(last_i))
    else $error("stalled token changed");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .token_kind_i   (res_o.token_kind),
  .start_line_i   (res_o.start_line),
  .start_column_i (res_o.start_column),
  .token_length_i (res_o.token_length),
  .last_i         (res_o.last)
);
